// ===== hdl/overlap_add_frame_to_hop_unit_assert.svh =====
// Assertion macros used by the accumulator store of the overlap-add block.
`ifndef OVERLAP_ADD_FRAME_TO_HOP_UNIT_ASSERT_SVH
`define OVERLAP_ADD_FRAME_TO_HOP_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define OFH_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Next-cycle implication, checked outside reset.
`define OFH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ofh_pkg.sv =====
// Shared types, constants and helpers of the overlap-add block.
package ofh_pkg;

  localparam int unsigned CH_W    = 3;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned ACC_W   = 24;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned CIDX_W  = 2;

  localparam int unsigned CHANNELS_MAX_DEF = 8;
  localparam int unsigned FRAME_MAX_DEF    = 1024;

  localparam logic [CFG_W-1:0] HOP_RST   = 11'd128;
  localparam logic [CFG_W-1:0] FRAME_RST = 11'd256;
  localparam logic [CNT_W-1:0] CHCNT_RST = 4'd1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 24'sh7FFFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = -24'sh800000;

  typedef enum logic [CIDX_W-1:0] {
    CFG_HOP   = 2'd0,
    CFG_FRAME = 2'd1,
    CFG_CHCNT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] hop;
    logic [CFG_W-1:0] frame;
    logic [CNT_W-1:0] chcnt;
  } cfg_t;

  // Word as it leaves the decode stage.
  typedef struct packed {
    logic [CH_W-1:0]         ch;
    logic [POS_W-1:0]        pos;
    logic signed [SMP_W-1:0] smp;
    logic                    src_ok;
    logic                    emit;
    logic                    last;
  } item_t;

  // Result word.
  typedef struct packed {
    logic [CH_W-1:0]         ch;
    logic [POS_W-1:0]        pos;
    logic signed [ACC_W-1:0] acc;
    logic                    last;
  } res_t;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    logic signed [ACC_W:0] hi;
    logic signed [ACC_W:0] lo;
    hi = {ACC_MAX[ACC_W-1], ACC_MAX};
    lo = {ACC_MIN[ACC_W-1], ACC_MIN};
    if (v > hi) begin
      return ACC_MAX;
    end else if (v < lo) begin
      return ACC_MIN;
    end
    return v[ACC_W-1:0];
  endfunction

endpackage

// ===== hdl/overlap_add_frame_to_hop_unit.sv =====
// Top level of the multichannel overlap-add (frame to hop) block.
//
// Input channel: one word per frame sample (channel_i, position_i, sample_i),
// taken when in_valid_i is high and in_stall_o is low. Words for channels at
// or above channel_count, or positions at or above frame_size, are taken and
// dropped. Each kept word reads the accumulator at position+hop (zero past the
// frame), adds the sample, saturates to 24 bits, writes it back at position.
// Output channel: positions below hop_size produce one word (out_channel_o,
// out_position_o, out_sample_o, last_of_hop_o), taken when out_valid_o is
// high and out_stall_i is low.
// Throughput: one word per cycle unless the clearing sweep or out_stall_i holds
// the pipe. A taken word loads the decode register, then the store read register,
// then the output register, which raises out_valid_o.
// A same-address write in flight is forwarded around the store read.
// Reset: config returns to hop 128, frame 256, one channel; the store is then
// cleared one entry per cycle, all CHANNELS_MAX*FRAME_MAX entries (8192 with
// defaults), while in_stall_o stays high. Config writes are taken at any time.
// Stall: a stalled output holds its word; stages behind it keep filling, and
// words without a result keep retiring, until the pipe backs up to the input.
module overlap_add_frame_to_hop_unit #(
  parameter int unsigned CHANNELS_MAX = ofh_pkg::CHANNELS_MAX_DEF,
  parameter int unsigned FRAME_MAX    = ofh_pkg::FRAME_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ofh_pkg::CIDX_W-1:0]        cfg_idx_i,
  input  logic [ofh_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ofh_pkg::CH_W-1:0]          channel_i,
  input  logic [ofh_pkg::POS_W-1:0]         position_i,
  input  logic signed [ofh_pkg::SMP_W-1:0]  sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ofh_pkg::CH_W-1:0]          out_channel_o,
  output logic [ofh_pkg::POS_W-1:0]         out_position_o,
  output logic signed [ofh_pkg::ACC_W-1:0]  out_sample_o,
  output logic                              last_of_hop_o
);
  import ofh_pkg::*;

  localparam int unsigned ADDR_W = $clog2(CHANNELS_MAX * FRAME_MAX);

  cfg_t              cfg;
  logic              busy;
  logic              s1_valid, s2_free;
  item_t             s1_item;
  logic [ADDR_W-1:0] s1_rd_addr, s1_wr_addr;
  logic              res_valid, s3_free;
  res_t              res;
  logic              out_valid_q, out_valid_d;
  res_t              out_q;

  ofh_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ofh_decode #(
    .CHANNELS_MAX (CHANNELS_MAX),
    .FRAME_MAX    (FRAME_MAX),
    .ADDR_W       (ADDR_W)
  ) u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .channel_i    (channel_i),
    .position_i   (position_i),
    .sample_i     (sample_i),
    .busy_i       (busy),
    .s2_free_i    (s2_free),
    .s1_valid_o   (s1_valid),
    .s1_item_o    (s1_item),
    .s1_rd_addr_o (s1_rd_addr),
    .s1_wr_addr_o (s1_wr_addr)
  );

  ofh_accum #(
    .CHANNELS_MAX (CHANNELS_MAX),
    .FRAME_MAX    (FRAME_MAX),
    .ADDR_W       (ADDR_W)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .busy_o       (busy),
    .s1_valid_i   (s1_valid),
    .s1_item_i    (s1_item),
    .s1_rd_addr_i (s1_rd_addr),
    .s1_wr_addr_i (s1_wr_addr),
    .s2_free_o    (s2_free),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .s3_free_i    (s3_free)
  );

  // Output register: load when empty or when the held word is taken.
  assign s3_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (s3_free) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_free && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_channel_o  = out_q.ch;
  assign out_position_o = out_q.pos;
  assign out_sample_o   = out_q.acc;
  assign last_of_hop_o  = out_q.last;

endmodule

// ===== hdl/ofh_cfg_regs.sv =====
// Configuration registers of the overlap-add block.
module ofh_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ofh_pkg::CIDX_W-1:0]  cfg_idx_i,
  input  logic [ofh_pkg::CFG_W-1:0]   cfg_wdata_i,
  output ofh_pkg::cfg_t               cfg_o
);
  import ofh_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HOP:   cfg_d.hop   = cfg_wdata_i;
        CFG_FRAME: cfg_d.frame = cfg_wdata_i;
        CFG_CHCNT: cfg_d.chcnt = cfg_wdata_i[CNT_W-1:0];
        default:   cfg_d = cfg_q; // index beyond the list: drop
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hop   <= HOP_RST;
      cfg_q.frame <= FRAME_RST;
      cfg_q.chcnt <= CHCNT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/ofh_decode.sv =====
// Decode stage: range checks, source and target addresses.
module ofh_decode #(
  parameter int unsigned CHANNELS_MAX = ofh_pkg::CHANNELS_MAX_DEF,
  parameter int unsigned FRAME_MAX    = ofh_pkg::FRAME_MAX_DEF,
  parameter int unsigned ADDR_W       = $clog2(CHANNELS_MAX * FRAME_MAX)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ofh_pkg::cfg_t                      cfg_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ofh_pkg::CH_W-1:0]           channel_i,
  input  logic [ofh_pkg::POS_W-1:0]          position_i,
  input  logic signed [ofh_pkg::SMP_W-1:0]   sample_i,
  input  logic                               busy_i,
  input  logic                               s2_free_i,
  output logic                               s1_valid_o,
  output ofh_pkg::item_t                     s1_item_o,
  output logic [ADDR_W-1:0]                  s1_rd_addr_o,
  output logic [ADDR_W-1:0]                  s1_wr_addr_o
);
  import ofh_pkg::*;

  logic                  s1_valid_q, s1_valid_d;
  item_t                 s1_item_q;
  logic [ADDR_W-1:0]     s1_rd_addr_q, s1_wr_addr_q;
  logic                  accept, adv1, s1_free;
  logic                  ch_ok, pos_ok, upd;
  logic [CFG_W:0]        src;
  logic [31:0]           base;
  item_t                 item_d;

  always_comb begin
    ch_ok  = ({1'b0, channel_i} < cfg_i.chcnt) && (32'(channel_i) < CHANNELS_MAX);
    pos_ok = ({1'b0, position_i} < cfg_i.frame) && (32'(position_i) < FRAME_MAX);
    upd    = ch_ok && pos_ok;
    src    = (CFG_W+1)'(position_i) + (CFG_W+1)'(cfg_i.hop);
    base   = 32'(channel_i) * 32'(FRAME_MAX);

    item_d.ch     = channel_i;
    item_d.pos    = position_i;
    item_d.smp    = sample_i;
    item_d.src_ok = (src < (CFG_W+1)'(cfg_i.frame)) && (32'(src) < FRAME_MAX);
    item_d.emit   = {1'b0, position_i} < cfg_i.hop;
    item_d.last   = (CFG_W'(position_i) + CFG_W'(1)) == cfg_i.hop;
  end

  assign adv1       = s1_valid_q && s2_free_i;
  assign s1_free    = !s1_valid_q || adv1;
  assign in_stall_o = busy_i || !s1_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Drop words for unused channels or positions past the frame here.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = upd;
    end else if (adv1) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q    <= item_d;
      s1_wr_addr_q <= ADDR_W'(base + 32'(position_i));
      s1_rd_addr_q <= item_d.src_ok ? ADDR_W'(base + 32'(src)) : ADDR_W'(base + 32'(position_i));
    end
  end

  assign s1_valid_o   = s1_valid_q;
  assign s1_item_o    = s1_item_q;
  assign s1_rd_addr_o = s1_rd_addr_q;
  assign s1_wr_addr_o = s1_wr_addr_q;

endmodule

// ===== hdl/ofh_accum.sv =====
// Accumulator store: clearing sweep, read stage with bypass, add and write back.
`include "overlap_add_frame_to_hop_unit_assert.svh"

module ofh_accum #(
  parameter int unsigned CHANNELS_MAX = ofh_pkg::CHANNELS_MAX_DEF,
  parameter int unsigned FRAME_MAX    = ofh_pkg::FRAME_MAX_DEF,
  parameter int unsigned ADDR_W       = $clog2(CHANNELS_MAX * FRAME_MAX)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  output logic                busy_o,
  input  logic                s1_valid_i,
  input  ofh_pkg::item_t      s1_item_i,
  input  logic [ADDR_W-1:0]   s1_rd_addr_i,
  input  logic [ADDR_W-1:0]   s1_wr_addr_i,
  output logic                s2_free_o,
  output logic                res_valid_o,
  output ofh_pkg::res_t       res_o,
  input  logic                s3_free_i
);
  import ofh_pkg::*;

  localparam int unsigned DEPTH = CHANNELS_MAX * FRAME_MAX;

  logic signed [ACC_W-1:0] mem [DEPTH];

  logic                    clearing_q;
  logic [ADDR_W-1:0]       clr_cnt_q;
  logic                    s2_valid_q, s2_valid_d;
  item_t                   s2_item_q;
  logic [ADDR_W-1:0]       s2_wr_addr_q;
  logic signed [ACC_W-1:0] rd_q;
  logic                    byp_hit_q, byp_hit_d;
  logic signed [ACC_W-1:0] byp_data_q;
  logic signed [ACC_W-1:0] old_val, sum;
  logic                    adv1, adv2;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic signed [ACC_W-1:0] wr_data;

  // Sweep zeros through the store after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
    end
  end

  assign busy_o = clearing_q;

  // Word in the add stage retires when it has no result or the output has room.
  assign adv2      = s2_valid_q && (!s2_item_q.emit || s3_free_i);
  assign s2_free_o = !s2_valid_q || adv2;
  assign adv1      = s1_valid_i && s2_free_o;

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (adv1) begin
      s2_valid_d = 1'b1;
    end else if (adv2) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
    end
  end

  // Forward the write that lands in the same cycle as the read.
  assign byp_hit_d = adv2 && (s2_wr_addr_q == s1_rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s2_item_q    <= s1_item_i;
      s2_wr_addr_q <= s1_wr_addr_i;
      byp_hit_q    <= byp_hit_d;
      byp_data_q   <= sum;
    end
  end

  always_comb begin
    if (!s2_item_q.src_ok) begin
      old_val = '0;
    end else if (byp_hit_q) begin
      old_val = byp_data_q;
    end else begin
      old_val = rd_q;
    end
    sum = sat_acc((ACC_W+1)'(old_val) + (ACC_W+1)'(s2_item_q.smp));
  end

  assign wr_en   = clearing_q || adv2;
  assign wr_addr = clearing_q ? clr_cnt_q : s2_wr_addr_q;
  assign wr_data = clearing_q ? '0 : sum;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (adv1) begin
      rd_q <= mem[s1_rd_addr_i];
    end
  end

  assign res_valid_o = s2_valid_q && s2_item_q.emit;
  assign res_o.ch    = s2_item_q.ch;
  assign res_o.pos   = s2_item_q.pos;
  assign res_o.acc   = sum;
  assign res_o.last  = s2_item_q.last;

  `OFH_ASSERT(a_clear_quiet, clk_i, rst_ni, clearing_q |-> !s2_valid_q && !s1_valid_i, "word in flight during clearing sweep")
  `OFH_ASSERT(a_clear_len, clk_i, rst_ni, $fell(clearing_q) |-> $past(clr_cnt_q) == ADDR_W'(DEPTH - 1), "clearing sweep ended early")
  `OFH_ASSERT(a_wr_range, clk_i, rst_ni, wr_en |-> 32'(wr_addr) < DEPTH, "store write out of range")
  `OFH_ASSERT_NEXT(a_s2_drain, clk_i, rst_ni, adv2 && !adv1, !s2_valid_q, "add stage kept a retired word")

endmodule

// ===== sim/tb_overlap_add_frame_to_hop_unit.sv =====
// Self-checking testbench for the multichannel overlap-add (frame to hop) block.
module tb_overlap_add_frame_to_hop_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ofh_pkg::*;

  localparam int unsigned ROWS     = CHANNELS_MAX_DEF;
  localparam int unsigned ROW_LEN  = FRAME_MAX_DEF;
  // Index past the register list; writes there must be ignored.
  localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;
  // Pipeline is three deep; give it some slack before touching registers.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_PCT      = 34;
  localparam int unsigned HOLD_CYCLES   = 300;

  // One frame sample as offered on the input channel.
  typedef struct {
    logic [CH_W-1:0]         ch;
    logic [POS_W-1:0]        pos;
    logic signed [SMP_W-1:0] smp;
  } frame_word_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CIDX_W-1:0]        cfg_idx_i = '0;
  logic [CFG_W-1:0]         cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [CH_W-1:0]          channel_i = '0;
  logic [POS_W-1:0]         position_i = '0;
  logic signed [SMP_W-1:0]  sample_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [CH_W-1:0]          out_channel_o;
  logic [POS_W-1:0]         out_position_o;
  logic signed [ACC_W-1:0]  out_sample_o;
  logic                     last_of_hop_o;

  overlap_add_frame_to_hop_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .channel_i     (channel_i),
    .position_i    (position_i),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_channel_o (out_channel_o),
    .out_position_o(out_position_o),
    .out_sample_o  (out_sample_o),
    .last_of_hop_o (last_of_hop_o)
  );

  always #2 clk_i = ~clk_i;

  // Shadow of the block's registers and accumulator rows.
  logic [CFG_W-1:0]        hop_cfg   = HOP_RST;
  logic [CFG_W-1:0]        frame_cfg = FRAME_RST;
  logic [CNT_W-1:0]        chans_cfg = CHCNT_RST;
  logic signed [ACC_W-1:0] acc_rows [ROWS*ROW_LEN];

  frame_word_t frame_words_q [$];  // words waiting to be offered
  res_t        hop_samples_q [$];  // hop samples still owed by the block

  int unsigned mismatches = 0;
  int unsigned kept_words = 0;     // words that land inside a frame of a live channel
  logic        steady = 1'b0;      // suppress idling on both sides
  logic        hold_req = 1'b0;    // ask the receiver for one long hold-off
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  initial begin
    foreach (acc_rows[i]) acc_rows[i] = '0;
  end

  // Overlap-add one word into the shadow rows; return 1 when it emits a hop sample.
  function automatic bit overlap_add(input frame_word_t w, output res_t hs);
    int unsigned src;
    int          sum;
    if (w.ch >= chans_cfg || w.ch >= ROWS || w.pos >= frame_cfg || w.pos >= ROW_LEN) begin
      return 1'b0;
    end
    src = w.pos + hop_cfg;
    sum = int'(w.smp);
    if (src < frame_cfg && src < ROW_LEN) begin
      sum = sum + int'(acc_rows[w.ch*ROW_LEN + src]);
    end
    if (sum > int'(ACC_MAX)) begin
      sum = int'(ACC_MAX);
    end else if (sum < int'(ACC_MIN)) begin
      sum = int'(ACC_MIN);
    end
    acc_rows[w.ch*ROW_LEN + w.pos] = sum[ACC_W-1:0];
    if (w.pos >= hop_cfg) begin
      return 1'b0;
    end
    hs.ch   = w.ch;
    hs.pos  = w.pos;
    hs.acc  = sum[ACC_W-1:0];
    hs.last = (w.pos + 1 == hop_cfg);
    return 1'b1;
  endfunction

  // Driver: predict on acceptance, then advance to the next word or idle.
  always @(posedge clk_i) begin
    frame_word_t w;
    res_t        hs;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        w.ch  = channel_i;
        w.pos = position_i;
        w.smp = sample_i;
        if (overlap_add(w, hs)) begin
          hop_samples_q.push_back(hs);
        end
      end
      // Hold a stalled word; only pick a new one once the old one is gone.
      if (!in_valid_i || !in_stall_o) begin
        if (frame_words_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          w = frame_words_q.pop_front();
          in_valid_i <= 1'b1;
          channel_i  <= w.ch;
          position_i <= w.pos;
          sample_i   <= w.smp;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken hop sample against the oldest prediction.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (hop_samples_q.size() == 0) begin
          $display("%0t: hop sample expected none got ch=%0d pos=%0d sample=%0d last=%0b",
                   $time, out_channel_o, out_position_o, out_sample_o, last_of_hop_o);
          mismatches++;
        end else begin
          want = hop_samples_q.pop_front();
          if (out_channel_o !== want.ch) begin
            $display("%0t: out_channel expected %0d got %0d", $time, want.ch, out_channel_o);
            mismatches++;
          end
          if (out_position_o !== want.pos) begin
            $display("%0t: out_position expected %0d got %0d", $time, want.pos,
                     out_position_o);
            mismatches++;
          end
          if (out_sample_o !== want.acc) begin
            $display("%0t: out_sample expected %0d got %0d", $time, want.acc, out_sample_o);
            mismatches++;
          end
          if (last_of_hop_o !== want.last) begin
            $display("%0t: last_of_hop expected %0b got %0b", $time, want.last,
                     last_of_hop_o);
            mismatches++;
          end
        end
      end
      // One long hold-off so the pipe backs up into the input; random stalls otherwise.
      if (hold_req && !hold_seen) begin
        hold_seen   <= 1'b1;
        hold_left   <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic queue_word(input logic [CH_W-1:0] ch, input logic [POS_W-1:0] pos,
                            input logic signed [SMP_W-1:0] smp);
    frame_word_t w;
    w.ch  = ch;
    w.pos = pos;
    w.smp = smp;
    frame_words_q.push_back(w);
    if (ch < chans_cfg && pos < frame_cfg) begin
      kept_words++;
    end
  endtask

  // Mostly random samples, with the two rails drawn often enough to hit saturation.
  function automatic logic signed [SMP_W-1:0] draw_sample();
    int unsigned pick;
    pick = $urandom_range(7);
    if (pick == 0) begin
      return 16'sh7FFF;
    end else if (pick == 1) begin
      return 16'sh8000;
    end
    return SMP_W'($urandom);
  endfunction

  // Queue whole frames channel by channel with rising positions; sprinkle in noise
  // and skipped positions. Large frames are thinned so each row stays short.
  task automatic queue_frames(input int unsigned n_frames, input int unsigned noise_pct);
    int unsigned chans;
    int unsigned stride;
    int unsigned p;
    chans  = (chans_cfg > ROWS) ? ROWS : chans_cfg;
    stride = frame_cfg / 24 + 1;
    for (int unsigned f = 0; f < n_frames; f++) begin
      for (int unsigned c = 0; c < chans; c++) begin
        p = 0;
        while (p < frame_cfg && p < ROW_LEN) begin
          if ($urandom_range(99) < noise_pct) begin
            if ($urandom_range(1) == 0) begin
              p = p + $urandom_range(2, 4);
            end else begin
              queue_word(CH_W'($urandom_range(ROWS-1)), POS_W'($urandom_range(ROW_LEN-1)),
                         draw_sample());
            end
          end else begin
            queue_word(CH_W'(c), POS_W'(p), draw_sample());
            p = p + $urandom_range(1, stride);
          end
        end
      end
    end
  endtask

  // Wait until every word is taken and every hop sample is back, then let the pipe empty.
  task automatic settle();
    do @(negedge clk_i);
    while (frame_words_q.size() != 0 || in_valid_i || hop_samples_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_HOP:   hop_cfg = data;
      CFG_FRAME: frame_cfg = data;
      CFG_CHCNT: chans_cfg = data[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_shape(input logic [CFG_W-1:0] hop, input logic [CFG_W-1:0] frame,
                           input logic [CFG_W-1:0] chans);
    write_reg(CFG_HOP, hop);
    write_reg(CFG_FRAME, frame);
    write_reg(CFG_CHCNT, chans);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned goal;
    int unsigned frame_len;
    int unsigned hop_len;
    int unsigned chans;
    int unsigned phase;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset shape: hop 128, frame 256, one channel. Edges of hop and frame, dropped words.
    queue_word(0, 0, 16'sh7FFF);
    queue_word(0, 127, 16'sh8000);
    queue_word(0, 128, 16'sd5);
    queue_word(0, 255, -16'sd1);
    queue_word(0, 256, 16'sd7);
    queue_word(1, 0, 16'sd9);
    queue_word(7, 1023, 16'sd11);
    settle();

    // Spare index must do nothing; channel count carries junk in its upper bits.
    write_reg(CFG_SPARE, 11'h7FF);
    set_shape(11'd1024, 11'h7FF, 11'h7F8);
    queue_word(7, 1023, 16'sh7FFF);
    queue_word(3, 512, 16'sh8000);
    queue_word(0, 0, 16'sh5555);
    queue_word(5, 1000, 16'shAAAA);
    settle();

    // Zero hop: rewrite in place with no output, then read it back through a hop of one.
    set_shape(11'd0, 11'd2, 11'd2);
    queue_word(1, 1, 16'sd100);
    queue_word(1, 1, 16'sd100);
    settle();
    set_shape(11'd1, 11'd2, 11'd2);
    queue_word(1, 0, 16'sd0);
    queue_word(1, 1, 16'sd3);
    settle();

    // Hop wider than the frame: every position inside the frame reads zero and emits.
    set_shape(11'd3, 11'd2, 11'd1);
    queue_word(0, 0, 16'sd1234);
    queue_word(0, 1, -16'sd4321);
    queue_word(0, 2, 16'sd77);
    settle();

    // No channels live: everything is dropped.
    set_shape(11'd4, 11'd8, 11'd0);
    queue_word(0, 0, 16'sd55);
    settle();

    // Drive row 0 to the top rail, then emit across the rail.
    set_shape(11'd0, 11'd2, 11'd2);
    for (int i = 0; i < 258; i++) begin
      queue_word(0, 1, 16'sh7FFF);
    end
    settle();
    set_shape(11'd1, 11'd2, 11'd2);
    queue_word(0, 0, 16'sh7FFF);
    queue_word(1, 0, 16'sh8000);
    queue_word(0, 1, 16'sd1);
    queue_word(0, 0, -16'sd2);
    settle();

    // Back-pressure: receiver holds off while the sender keeps offering.
    set_shape(11'd16, 11'd16, 11'd2);
    steady   <= 1'b1;
    hold_req <= 1'b1;
    queue_frames(2, 0);
    settle();
    steady <= 1'b0;

    // Random shapes, mostly small frames, with one phase free of idling.
    goal  = kept_words + 180;
    phase = 0;
    while (kept_words < goal || phase < 2) begin
      frame_len = ($urandom_range(9) == 0) ? $urandom_range(25, 2047) : $urandom_range(1, 24);
      hop_len   = ($urandom_range(9) == 0) ? $urandom_range(0, 2047)
                                           : $urandom_range(0, frame_len);
      chans     = ($urandom_range(9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      set_shape(CFG_W'(hop_len), CFG_W'(frame_len), {7'($urandom), 4'(chans)});
      if (phase == 1) begin
        steady <= 1'b1;
      end
      queue_frames($urandom_range(1, 2), 8);
      settle();
      steady <= 1'b0;
      phase++;
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: covers the store clear after reset and the slowest legal run many times over.
  initial begin
    #1ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ofh_pkg.sv
hdl/ofh_cfg_regs.sv
hdl/ofh_decode.sv
hdl/ofh_accum.sv
hdl/overlap_add_frame_to_hop_unit.sv
sim/tb_overlap_add_frame_to_hop_unit.sv
